@@ rtl/assert_macros.svh @@
// assertion macros used by hsv_picker_plane_to_rgb
// no dependencies; taken in by `include where assertions are written
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define HSVP_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define HSVP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/hsvp_pkg.sv @@
// hsvp_pkg: constants, types and helper functions of the hsv picker plane
// no dependencies; used by hsvp_frac_div and hsv_picker_plane_to_rgb
`default_nettype none

package hsvp_pkg;

   localparam int MAX_DIMENSION = 4096;
   localparam int FRACTION_BITS = 16;

   // field and register widths
   localparam int COORD_W     = 12;
   localparam int COLOR_W     = 8;
   localparam int LEVEL_W     = 8;
   localparam int HUE_W       = 9;
   localparam int MODE_W      = 2;
   localparam int DIM_W       = 13;
   localparam int CSR_DATA_W  = 13;
   localparam int CSR_INDEX_W = 3;

   localparam int HUE_WRAP       = 360;
   localparam int DEG_PER_SECTOR = 60;
   localparam int LEVEL_FULL     = 255;

   // divisor holds a span, the full level or degrees per sector
   localparam int SPAN_W = $clog2(MAX_DIMENSION);
   localparam int DEN_W  = (SPAN_W > 8) ? SPAN_W : 8;
   // dividend is up to six times a coordinate, a coordinate, a level or a hue
   localparam int NUM_W  = COORD_W + 3;
   // fixed point 0..1 inclusive, and 0..6 for the sector position
   localparam int FX_W     = FRACTION_BITS + 1;
   localparam int ALFA_W   = FRACTION_BITS + 3;
   localparam int SECTOR_W = ALFA_W - FRACTION_BITS;

   localparam logic [FX_W-1:0] ONE_FX = FX_W'(1) << FRACTION_BITS;

   // pipelined divider: a few quotient bits per stage
   localparam int DIV_STEPS_PER_STAGE = 4;
   localparam int DIV_STAGES =
      (ALFA_W + 1 + DIV_STEPS_PER_STAGE - 1) / DIV_STEPS_PER_STAGE;
   localparam int DIV_BITS = DIV_STAGES * DIV_STEPS_PER_STAGE;

   // pipeline stage indexes
   localparam int STG_OPERANDS = 0;
   localparam int STG_CHROMA   = DIV_STAGES + 1;
   localparam int STG_MIX      = DIV_STAGES + 2;
   localparam int STG_OUT      = DIV_STAGES + 3;
   localparam int NUM_STAGES   = DIV_STAGES + 4;

   typedef enum logic [MODE_W-1:0] {
      MODE_HUE        = 2'd0,
      MODE_SATURATION = 2'd1,
      MODE_VALUE      = 2'd2
   } plane_mode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PLANE_MODE       = 3'd0,
      CSR_HUE_DEGREES      = 3'd1,
      CSR_SATURATION_LEVEL = 3'd2,
      CSR_VALUE_LEVEL      = 3'd3,
      CSR_IMAGE_WIDTH      = 3'd4,
      CSR_IMAGE_HEIGHT     = 3'd5
   } csr_index_type;

   typedef enum logic [SECTOR_W-1:0] {
      SECTOR_RED_YELLOW    = 3'd0,
      SECTOR_YELLOW_GREEN  = 3'd1,
      SECTOR_GREEN_CYAN    = 3'd2,
      SECTOR_CYAN_BLUE     = 3'd3,
      SECTOR_BLUE_MAGENTA  = 3'd4,
      SECTOR_MAGENTA_RED   = 3'd5
   } sector_type;

   typedef struct packed {
      logic [COORD_W-1:0] pixel_x;
      logic [COORD_W-1:0] pixel_y;
   } req_payload_type;

   typedef struct packed {
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } rsp_payload_type;

   // dimension minus one, dimension limited to 2..MAX_DIMENSION
   function automatic logic [DEN_W-1:0] span_of(input logic [DIM_W-1:0] dim);
      logic [DEN_W-1:0] span;
      if (32'(dim) > 32'(MAX_DIMENSION)) begin
         span = DEN_W'(MAX_DIMENSION - 1);
      end else if (dim < DIM_W'(2)) begin
         span = DEN_W'(1);
      end else begin
         span = DEN_W'(dim - DIM_W'(1));
      end
      return span;
   endfunction

   // wrap once round the color circle
   function automatic logic [HUE_W-1:0] wrap_hue(input logic [HUE_W-1:0] hue);
      logic [HUE_W-1:0] wrapped;
      if (hue >= HUE_W'(HUE_WRAP)) begin
         wrapped = hue - HUE_W'(HUE_WRAP);
      end else begin
         wrapped = hue;
      end
      return wrapped;
   endfunction

   // (comp * 255) >> FRACTION_BITS, truncated
   function automatic logic [COLOR_W-1:0] to_byte(input logic [FX_W-1:0] comp);
      logic [FX_W+COLOR_W-1:0] scaled;
      scaled = {comp, COLOR_W'(0)} - (FX_W + COLOR_W)'(comp);
      return scaled[FRACTION_BITS+COLOR_W-1:FRACTION_BITS];
   endfunction

endpackage

`default_nettype wire

@@ rtl/hsvp_frac_div.sv @@
// hsvp_frac_div: pipelined restoring divider giving floor(num * 2^FRACTION_BITS / den)
// for num up to six times den; depends on hsvp_pkg
`default_nettype none

module hsvp_frac_div import hsvp_pkg::*; (
   input  logic                  clock,
   input  logic [DIV_STAGES-1:0] load_en,
   input  logic [NUM_W-1:0]      num,
   input  logic [DEN_W-1:0]      den,
   output logic [ALFA_W-1:0]     quot
);

   localparam int DIVIDEND_W = NUM_W + FRACTION_BITS;

   // pending dividend bits shift out at the top, quotient bits enter at the bottom
   logic [DEN_W-1:0]    rem_in [DIV_STAGES];
   logic [DEN_W-1:0]    rem_ff [DIV_STAGES];
   logic [DIV_BITS-1:0] pq_in  [DIV_STAGES];
   logic [DIV_BITS-1:0] pq_ff  [DIV_STAGES];
   logic [DEN_W-1:0]    den_in [DIV_STAGES];
   logic [DEN_W-1:0]    den_ff [DIV_STAGES];

   always_comb begin
      logic [DIVIDEND_W-1:0] dividend;
      logic [DEN_W-1:0]      rem_cur;
      logic [DIV_BITS-1:0]   pq_cur;
      logic [DEN_W-1:0]      den_cur;
      logic [DEN_W:0]        trial;
      logic                  fits;
      dividend = {num, FRACTION_BITS'(0)};
      for (int j = 0; j < DIV_STAGES; j++) begin
         if (j == 0) begin
            // top bits already below den, quotient there is zero
            rem_cur = DEN_W'(dividend >> DIV_BITS);
            pq_cur  = dividend[DIV_BITS-1:0];
            den_cur = den;
         end else begin
            rem_cur = rem_ff[j-1];
            pq_cur  = pq_ff[j-1];
            den_cur = den_ff[j-1];
         end
         for (int k = 0; k < DIV_STEPS_PER_STAGE; k++) begin
            trial  = {rem_cur, pq_cur[DIV_BITS-1]};
            fits   = (trial >= {1'b0, den_cur});
            pq_cur = {pq_cur[DIV_BITS-2:0], fits};
            if (fits) begin
               rem_cur = DEN_W'(trial - {1'b0, den_cur});
            end else begin
               rem_cur = DEN_W'(trial);
            end
         end
         rem_in[j] = rem_cur;
         pq_in[j]  = pq_cur;
         den_in[j] = den_cur;
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < DIV_STAGES; j++) begin
         if (load_en[j]) begin
            rem_ff[j] <= rem_in[j];
            pq_ff[j]  <= pq_in[j];
            den_ff[j] <= den_in[j];
         end
      end
   end

   assign quot = ALFA_W'(pq_ff[DIV_STAGES-1]);

endmodule

`default_nettype wire

@@ rtl/hsv_picker_plane_to_rgb.sv @@
// hsv_picker_plane_to_rgb: rgb color of an hsv picker plane at a pixel coordinate
// depends on hsvp_pkg, hsvp_frac_div and assert_macros.svh
//
//   channel  direction  handshake               payload
//   req      in         req_valid / req_stall   req_data  (pixel_x, pixel_y)
//   rsp      out        rsp_valid / rsp_stall   rsp_data  (red, green, blue)
//   csr      in         csr_wr_en               csr_index, csr_wdata
//
// one transaction per cycle unless a full pipeline is held by rsp_stall; from
// acceptance to rsp_valid the data passes the operand register, three side-by-side pipelined
// dividers (four quotient bits per stage), two multiplier stages, output register
// valid bits travel with the data; an empty stage takes new data even while
// the output is stalled, so req_stall rises only when every stage is full
// synchronous reset clears the valid bits and loads the register defaults
`default_nettype none
`include "assert_macros.svh"

module hsv_picker_plane_to_rgb import hsvp_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   // input transactions
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_payload_type        req_data,
   // result transactions
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_payload_type        rsp_data,
   // register writes
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // configuration; hue kept wrapped, dimensions kept as divisor spans
   logic [MODE_W-1:0]  mode_ff;
   logic [HUE_W-1:0]   hue_ff;
   logic [LEVEL_W-1:0] sat_ff;
   logic [LEVEL_W-1:0] val_ff;
   logic [DEN_W-1:0]   wspan_ff;
   logic [DEN_W-1:0]   hspan_ff;

   // pipeline flow control
   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES:0]   go;

   // operand stage
   logic [COORD_W-1:0] xs;
   logic [COORD_W-1:0] ys;
   logic [NUM_W-1:0]   x6;
   logic [NUM_W-1:0]   num_s_in, num_v_in, num_a_in;
   logic [DEN_W-1:0]   den_s_in, den_v_in, den_a_in;
   logic [NUM_W-1:0]   num_s_ff, num_v_ff, num_a_ff;
   logic [DEN_W-1:0]   den_s_ff, den_v_ff, den_a_ff;

   // divider results
   logic [ALFA_W-1:0] q_s, q_v, q_a;

   // chroma stage
   logic [FX_W-1:0]     s_fx, v_fx, m_fx, dist_fx;
   logic [2*FX_W-1:0]   prod_sv;
   logic [FX_W-1:0]     c_in, t_in;
   logic [SECTOR_W-1:0] int_part;
   sector_type          sector_in;
   logic [FX_W-1:0]     c_ff, t_ff, v1_ff;
   sector_type          sector1_ff;

   // mix stage
   logic [2*FX_W-1:0] prod_ct;
   logic [FX_W-1:0]   x_in, lo_in;
   logic [FX_W-1:0]   x_ff, lo_ff, v2_ff;
   sector_type        sector2_ff;

   // output stage
   logic [FX_W-1:0] mid_fx;
   logic [FX_W-1:0] r_fx, g_fx, b_fx;
   rsp_payload_type rsp_in;
   rsp_payload_type rsp_data_ff;

   // ---------------------------------------------------------------
   // register writes
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_HUE;
         hue_ff   <= '0;
         sat_ff   <= LEVEL_W'(LEVEL_FULL);
         val_ff   <= LEVEL_W'(LEVEL_FULL);
         wspan_ff <= span_of(DIM_W'(256));
         hspan_ff <= span_of(DIM_W'(256));
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_PLANE_MODE:       mode_ff  <= csr_wdata[MODE_W-1:0];
            CSR_HUE_DEGREES:      hue_ff   <= wrap_hue(csr_wdata[HUE_W-1:0]);
            CSR_SATURATION_LEVEL: sat_ff   <= csr_wdata[LEVEL_W-1:0];
            CSR_VALUE_LEVEL:      val_ff   <= csr_wdata[LEVEL_W-1:0];
            CSR_IMAGE_WIDTH:      wspan_ff <= span_of(csr_wdata[DIM_W-1:0]);
            CSR_IMAGE_HEIGHT:     hspan_ff <= span_of(csr_wdata[DIM_W-1:0]);
            default: ;  // indexes past the list are ignored
         endcase
      end
   end

   // ---------------------------------------------------------------
   // flow control: a stage loads when empty or when its data moves on
   // ---------------------------------------------------------------
   always_comb begin
      go[NUM_STAGES] = !rsp_stall;
      for (int k = NUM_STAGES - 1; k >= 0; k--) begin
         go[k] = !valid_ff[k] || go[k+1];
      end
   end

   assign req_stall = !go[STG_OPERANDS];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NUM_STAGES; k++) begin
            if (go[k]) begin
               valid_ff[k] <= (k == 0) ? req_valid : valid_ff[k-1];
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // operand stage: clamp coordinates, pick dividend and divisor per mode
   // ---------------------------------------------------------------
   always_comb begin
      // a coordinate past the image edge reads as the last pixel
      if (32'(req_data.pixel_x) > 32'(wspan_ff)) begin
         xs = COORD_W'(wspan_ff);
      end else begin
         xs = req_data.pixel_x;
      end
      if (32'(req_data.pixel_y) > 32'(hspan_ff)) begin
         ys = COORD_W'(hspan_ff);
      end else begin
         ys = req_data.pixel_y;
      end
      x6 = (NUM_W'(xs) << 2) + (NUM_W'(xs) << 1);

      case (mode_ff)
         MODE_SATURATION: begin
            num_s_in = NUM_W'(sat_ff);
            den_s_in = DEN_W'(LEVEL_FULL);
            num_v_in = NUM_W'(ys);
            den_v_in = hspan_ff;
            num_a_in = x6;
            den_a_in = wspan_ff;
         end
         MODE_VALUE: begin
            num_s_in = NUM_W'(ys);
            den_s_in = hspan_ff;
            num_v_in = NUM_W'(val_ff);
            den_v_in = DEN_W'(LEVEL_FULL);
            num_a_in = x6;
            den_a_in = wspan_ff;
         end
         default: begin
            // hue mode, and the unused fourth code
            num_s_in = NUM_W'(xs);
            den_s_in = wspan_ff;
            num_v_in = NUM_W'(ys);
            den_v_in = hspan_ff;
            num_a_in = NUM_W'(hue_ff);
            den_a_in = DEN_W'(DEG_PER_SECTOR);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (go[STG_OPERANDS]) begin
         num_s_ff <= num_s_in;
         den_s_ff <= den_s_in;
         num_v_ff <= num_v_in;
         den_v_ff <= den_v_in;
         num_a_ff <= num_a_in;
         den_a_ff <= den_a_in;
      end
   end

   // ---------------------------------------------------------------
   // saturation, value and sector position dividers
   // ---------------------------------------------------------------
   hsvp_frac_div u_div_sat (
      .clock   (clock),
      .load_en (go[DIV_STAGES:1]),
      .num     (num_s_ff),
      .den     (den_s_ff),
      .quot    (q_s)
   );

   hsvp_frac_div u_div_val (
      .clock   (clock),
      .load_en (go[DIV_STAGES:1]),
      .num     (num_v_ff),
      .den     (den_v_ff),
      .quot    (q_v)
   );

   hsvp_frac_div u_div_alfa (
      .clock   (clock),
      .load_en (go[DIV_STAGES:1]),
      .num     (num_a_ff),
      .den     (den_a_ff),
      .quot    (q_a)
   );

   // ---------------------------------------------------------------
   // chroma stage: c = s*v, triangle weight t, sector number
   // ---------------------------------------------------------------
   always_comb begin
      s_fx    = q_s[FX_W-1:0];
      v_fx    = q_v[FX_W-1:0];
      prod_sv = (2 * FX_W)'(s_fx) * (2 * FX_W)'(v_fx);
      c_in    = FX_W'(prod_sv >> FRACTION_BITS);

      // position within a pair of sectors, distance from its middle
      m_fx = q_a[FX_W-1:0];
      if (m_fx >= ONE_FX) begin
         dist_fx = m_fx - ONE_FX;
      end else begin
         dist_fx = ONE_FX - m_fx;
      end
      t_in = ONE_FX - dist_fx;

      // exactly on a sector edge belongs to the sector below it
      int_part = q_a[ALFA_W-1:FRACTION_BITS];
      if ((int_part != '0) && (q_a[FRACTION_BITS-1:0] == '0)) begin
         int_part = int_part - SECTOR_W'(1);
      end
      if (int_part > SECTOR_MAGENTA_RED) begin
         sector_in = SECTOR_MAGENTA_RED;
      end else begin
         sector_in = sector_type'(int_part);
      end
   end

   always_ff @(posedge clock) begin
      if (go[STG_CHROMA]) begin
         c_ff       <= c_in;
         t_ff       <= t_in;
         v1_ff      <= v_fx;
         sector1_ff <= sector_in;
      end
   end

   // ---------------------------------------------------------------
   // mix stage: x = c*t, floor level v - c
   // ---------------------------------------------------------------
   always_comb begin
      prod_ct = (2 * FX_W)'(c_ff) * (2 * FX_W)'(t_ff);
      x_in    = FX_W'(prod_ct >> FRACTION_BITS);
      lo_in   = v1_ff - c_ff;
   end

   always_ff @(posedge clock) begin
      if (go[STG_MIX]) begin
         x_ff       <= x_in;
         lo_ff      <= lo_in;
         v2_ff      <= v1_ff;
         sector2_ff <= sector1_ff;
      end
   end

   // ---------------------------------------------------------------
   // output stage: sector select and scaling to bytes
   // ---------------------------------------------------------------
   always_comb begin
      mid_fx = x_ff + lo_ff;
      case (sector2_ff)
         SECTOR_RED_YELLOW: begin
            r_fx = v2_ff;  g_fx = mid_fx; b_fx = lo_ff;
         end
         SECTOR_YELLOW_GREEN: begin
            r_fx = mid_fx; g_fx = v2_ff;  b_fx = lo_ff;
         end
         SECTOR_GREEN_CYAN: begin
            r_fx = lo_ff;  g_fx = v2_ff;  b_fx = mid_fx;
         end
         SECTOR_CYAN_BLUE: begin
            r_fx = lo_ff;  g_fx = mid_fx; b_fx = v2_ff;
         end
         SECTOR_BLUE_MAGENTA: begin
            r_fx = mid_fx; g_fx = lo_ff;  b_fx = v2_ff;
         end
         default: begin
            r_fx = v2_ff;  g_fx = lo_ff;  b_fx = mid_fx;
         end
      endcase
      rsp_in.red   = to_byte(r_fx);
      rsp_in.green = to_byte(g_fx);
      rsp_in.blue  = to_byte(b_fx);
   end

   always_ff @(posedge clock) begin
      if (go[STG_OUT]) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = valid_ff[STG_OUT];
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------
   `HSVP_ASSERT_IMPLY(a_span_nonzero, clock, reset, 1'b1,
      (wspan_ff != '0) && (hspan_ff != '0), "divisor span is zero")
   `HSVP_ASSERT_IMPLY(a_chroma_within_value, clock, reset, valid_ff[STG_CHROMA],
      (c_ff <= v1_ff) && (t_ff <= ONE_FX), "chroma above value or weight above one")
   `HSVP_ASSERT_IMPLY(a_full_pipe_stalls, clock, reset, (&valid_ff) && rsp_stall,
      req_stall, "full stalled pipeline still takes a transaction")
   `HSVP_ASSERT_NEXT(a_accept_enters, clock, reset, req_valid && !req_stall,
      valid_ff[STG_OPERANDS], "accepted transaction lost at entry")

endmodule

`default_nettype wire
